// ----- src/sbc_pkg.sv -----
// Shared types, widths and codes for the sensor bias calibration sequencer.
package sbc_pkg;

	// Sample and time widths
	localparam int TIME_W    = 32;
	localparam int GX_W      = 16;
	localparam int GZ_W      = 16;
	localparam int H_W       = 24;
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 2;

	// Sample count limit and derived accumulator widths
	localparam int MAX_SAMPLES = 65536;
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int LOG_MAX     = $clog2(MAX_SAMPLES);
	localparam int SUMX_W      = GX_W + LOG_MAX;
	localparam int SUMZ_W      = GZ_W + LOG_MAX;
	localparam int SUMH_W      = H_W + LOG_MAX;
	localparam int DIV_W       = SUMH_W;
	localparam int STEP_W      = $clog2(DIV_W);

	// Front-to-back queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Register reset values and indexes
	localparam logic [CFG_W-1:0]     WARM_RESET    = CFG_W'(3000);
	localparam logic [CFG_W-1:0]     CAL_RESET     = CFG_W'(2000);
	localparam logic [CFG_IDX_W-1:0] REG_WARM_TIME = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CAL_TIME  = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WARM = 2'd1,
		PH_CAL  = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	typedef enum logic {
		OP_STEP    = 1'b0,
		OP_RESTART = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		BS_RUN,
		BS_DIV,
		BS_FIN
	} bstate_t;

	typedef enum logic [1:0] {
		SEL_X,
		SEL_Z,
		SEL_H
	} dsel_t;

	typedef struct packed {
		op_t                      op;
		logic [TIME_W-1:0]        now;
		logic signed [GX_W-1:0]   gx;
		logic signed [GZ_W-1:0]   gz;
		logic signed [H_W-1:0]    gh;
	} item_t;

	typedef struct packed {
		logic [CFG_W-1:0] warm_time;
		logic [CFG_W-1:0] cal_time;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

endpackage

// ----- src/sbc_front.sv -----
// Front end: accepts input words, classifies them and queues them for the back end.
module sbc_front import sbc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   kind,
	input  logic [TIME_W-1:0]      now_ms,
	input  logic signed [GX_W-1:0] gyro_x,
	input  logic signed [GZ_W-1:0] gyro_z,
	input  logic signed [H_W-1:0]  height,
	output logic                   q_valid,
	output item_t                  q_item,
	input  logic                   q_pop
);

	item_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	item_t             item_in;
	logic              push;
	logic              pop;

	// Classify the incoming word
	always_comb begin
		item_in.op  = kind ? OP_RESTART : OP_STEP;
		item_in.now = now_ms;
		item_in.gx  = gyro_x;
		item_in.gz  = gyro_z;
		item_in.gh  = height;
	end

	assign in_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = slot_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/sbc_div.sv -----
// Iterative signed divider: one quotient bit per cycle, truncates toward zero.
module sbc_div import sbc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [DIV_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0]  abs_dividend;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    trial_diff;
	logic              ge;

	// Magnitude of the dividend (most negative value still fits as unsigned)
	assign abs_dividend = req.dividend[DIV_W-1] ? (~req.dividend + 1'b1) : req.dividend;

	// One restoring step
	assign trial      = {rem_q, quo_q[DIV_W-1]};
	assign trial_diff = trial - {1'b0, dvs_q};
	assign ge         = (trial >= {1'b0, dvs_q});

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[DIV_W-1];
			quo_q <= abs_dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

// ----- src/sbc_back.sv -----
// Back end: phase sequencer, accumulators, average division control and result register.
module sbc_back import sbc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   q_valid,
	input  item_t                  q_item,
	output logic                   q_pop,
	output div_req_t               div_req,
	input  div_rsp_t               div_rsp,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             phase,
	output logic                   offsets_done,
	output logic signed [GX_W-1:0] offset_x,
	output logic signed [GZ_W-1:0] offset_z,
	output logic signed [H_W-1:0]  zero_height,
	output logic                   handoff
);

	bstate_t            state_q, state_d;
	phase_t             phase_q, phase_d;
	dsel_t              sel_q;
	logic               div_start_q;
	logic [TIME_W-1:0]  start_q;
	logic [SUMX_W-1:0]  sum_x_q;
	logic [SUMZ_W-1:0]  sum_z_q;
	logic [SUMH_W-1:0]  sum_h_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [GX_W-1:0]    held_x_q, held_x_d;
	logic [GZ_W-1:0]    held_z_q, held_z_d;
	logic [H_W-1:0]     held_h_q, held_h_d;

	logic               out_valid_q;
	phase_t             out_phase_q;
	logic               out_done_q;
	logic               out_hand_q;
	logic [GX_W-1:0]    out_x_q;
	logic [GZ_W-1:0]    out_z_q;
	logic [H_W-1:0]     out_h_q;

	logic               slot_free;
	logic [TIME_W-1:0]  elapsed;
	logic               emit;
	logic               load_start;
	logic               clear_acc;
	logic               accum;
	logic               go_div;
	logic               zero_held;
	logic               done_d;
	logic               hand_d;

	assign slot_free = !out_valid_q || out_ready;
	assign elapsed   = q_item.now - start_q;

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control
	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		q_pop      = 1'b0;
		emit       = 1'b0;
		load_start = 1'b0;
		clear_acc  = 1'b0;
		accum      = 1'b0;
		go_div     = 1'b0;
		zero_held  = 1'b0;
		done_d     = 1'b0;
		hand_d     = 1'b0;
		case (state_q)
			BS_RUN: begin
				if (q_valid && slot_free) begin
					q_pop = 1'b1;
					emit  = 1'b1;
					if (q_item.op == OP_RESTART) begin
						phase_d = PH_IDLE;
					end else begin
						case (phase_q)
							PH_IDLE: begin
								phase_d    = PH_WARM;
								load_start = 1'b1;
							end
							PH_WARM: begin
								if (elapsed >= TIME_W'(cfg.warm_time)) begin
									phase_d    = PH_CAL;
									clear_acc  = 1'b1;
									load_start = 1'b1;
								end
							end
							PH_CAL: begin
								if (elapsed >= TIME_W'(cfg.cal_time)) begin
									phase_d = PH_DONE;
									if (cnt_q == '0) begin
										zero_held = 1'b1;
										done_d    = 1'b1;
									end else begin
										// result waits for the three averages
										emit    = 1'b0;
										go_div  = 1'b1;
										state_d = BS_DIV;
									end
								end else if (cnt_q < CNT_W'(MAX_SAMPLES)) begin
									accum = 1'b1;
								end
							end
							PH_DONE: begin
								hand_d = 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
			end
			BS_DIV: begin
				if (div_rsp.done && sel_q == SEL_H) begin
					state_d = BS_FIN;
				end
			end
			BS_FIN: begin
				if (slot_free) begin
					emit    = 1'b1;
					done_d  = 1'b1;
					state_d = BS_RUN;
				end
			end
			default: begin
				state_d = BS_RUN;
			end
		endcase
	end

	// Held averages: cleared on an empty run, filled one by one by the divider
	always_comb begin
		held_x_d = held_x_q;
		held_z_d = held_z_q;
		held_h_d = held_h_q;
		if (zero_held) begin
			held_x_d = '0;
			held_z_d = '0;
			held_h_d = '0;
		end else if (state_q == BS_DIV && div_rsp.done) begin
			case (sel_q)
				SEL_X:   held_x_d = div_rsp.quot[GX_W-1:0];
				SEL_Z:   held_z_d = div_rsp.quot[GZ_W-1:0];
				SEL_H:   held_h_d = div_rsp.quot[H_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Divider request
	always_comb begin
		div_req.start   = div_start_q;
		div_req.divisor = cnt_q;
		case (sel_q)
			SEL_X:   div_req.dividend = {{(DIV_W-SUMX_W){sum_x_q[SUMX_W-1]}}, sum_x_q};
			SEL_Z:   div_req.dividend = {{(DIV_W-SUMZ_W){sum_z_q[SUMZ_W-1]}}, sum_z_q};
			default: div_req.dividend = sum_h_q;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			sel_q       <= SEL_X;
			div_start_q <= 1'b0;
			start_q     <= '0;
			sum_x_q     <= '0;
			sum_z_q     <= '0;
			sum_h_q     <= '0;
			cnt_q       <= '0;
			held_x_q    <= '0;
			held_z_q    <= '0;
			held_h_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			held_x_q    <= held_x_d;
			held_z_q    <= held_z_d;
			held_h_q    <= held_h_d;
			div_start_q <= 1'b0;
			if (load_start) begin
				start_q <= q_item.now;
			end
			if (clear_acc) begin
				sum_x_q <= '0;
				sum_z_q <= '0;
				sum_h_q <= '0;
				cnt_q   <= '0;
			end else if (accum) begin
				sum_x_q <= sum_x_q + {{(SUMX_W-GX_W){q_item.gx[GX_W-1]}}, q_item.gx};
				sum_z_q <= sum_z_q + {{(SUMZ_W-GZ_W){q_item.gz[GZ_W-1]}}, q_item.gz};
				sum_h_q <= sum_h_q + {{(SUMH_W-H_W){q_item.gh[H_W-1]}}, q_item.gh};
				cnt_q   <= cnt_q + 1'b1;
			end
			// walk X, Z, H through the divider
			if (go_div) begin
				sel_q       <= SEL_X;
				div_start_q <= 1'b1;
			end else if (state_q == BS_DIV && div_rsp.done) begin
				case (sel_q)
					SEL_X: begin
						sel_q       <= SEL_Z;
						div_start_q <= 1'b1;
					end
					SEL_Z: begin
						sel_q       <= SEL_H;
						div_start_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result word
	always_ff @(posedge clk) begin
		if (emit) begin
			out_phase_q <= phase_d;
			out_done_q  <= done_d;
			out_hand_q  <= hand_d;
			out_x_q     <= held_x_d;
			out_z_q     <= held_z_d;
			out_h_q     <= held_h_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign phase        = out_phase_q;
	assign offsets_done = out_done_q;
	assign handoff      = out_hand_q;
	assign offset_x     = out_x_q;
	assign offset_z     = out_z_q;
	assign zero_height  = out_h_q;

	// Checks
	a_start_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_start_q |-> state_q == BS_DIV)
		else $error("divider started outside the divide state");

	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_done_q) |-> out_phase_q == PH_DONE)
		else $error("offsets_done without done phase");

	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_hand_q) |-> (out_phase_q == PH_DONE && !out_done_q))
		else $error("handoff outside done phase or together with offsets_done");

	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_SAMPLES))
		else $error("sample count past its limit");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BS_RUN) |-> !q_pop)
		else $error("queue popped while averages are computed");

endmodule

// ----- src/sensor_bias_calibration_sequencer_unit.sv -----
// Top level of the sensor bias calibration sequencer: registers, front, back and divider.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | kind, now_ms, gyro_x, gyro_z, height
//  out     | out_valid/ out_ready | phase, offsets_done, offset_x, offset_z,
//          |                      | zero_height, handoff
//  cfg     | cfg_valid/ cfg_ready | cfg_index, cfg_data (0 warm time, 1 cal time)
//
// The back end takes one word per cycle while it is in its run state and the result slot is
// free; an accepted input word passes the queue, then the result register, to its result word.
// The word that ends calibration with samples runs three divisions on the shared divider;
// its result word is then registered once the result slot is free.
// A two-entry queue lets the input side keep taking words while the back end stalls, until it is full.
// cfg_ready is always high; reset loads 3000 ms warm-up and 2000 ms calibration time.
module sensor_bias_calibration_sequencer_unit import sbc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   kind,
	input  logic [TIME_W-1:0]      now_ms,
	input  logic signed [GX_W-1:0] gyro_x,
	input  logic signed [GZ_W-1:0] gyro_z,
	input  logic signed [H_W-1:0]  height,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             phase,
	output logic                   offsets_done,
	output logic signed [GX_W-1:0] offset_x,
	output logic signed [GZ_W-1:0] offset_z,
	output logic signed [H_W-1:0]  zero_height,
	output logic                   handoff,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	cfg_t     cfg_q;
	logic     q_valid;
	item_t    q_item;
	logic     q_pop;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.warm_time <= WARM_RESET;
			cfg_q.cal_time  <= CAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WARM_TIME: cfg_q.warm_time <= cfg_data;
				REG_CAL_TIME:  cfg_q.cal_time  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sbc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.now_ms   (now_ms),
		.gyro_x   (gyro_x),
		.gyro_z   (gyro_z),
		.height   (height),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	sbc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	sbc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.div_req      (div_req),
		.div_rsp      (div_rsp),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.phase        (phase),
		.offsets_done (offsets_done),
		.offset_x     (offset_x),
		.offset_z     (offset_z),
		.zero_height  (zero_height),
		.handoff      (handoff)
	);

endmodule
